### design/wcts_pkg.sv
// ----------------------------------------------------------------------------
// wcts_pkg
// shared constants for the wall column texture sampler: field widths, default
// sizes, request codes, texture codes, quadrant angles and register indexes
// ----------------------------------------------------------------------------
package wcts_pkg;

    localparam int TEX_DIM_DEF     = 64;
    localparam int SCREEN_ROWS_DEF = 1024;
    localparam int TEX_COUNT       = 5;
    localparam int DIM_RESET       = 64;

    localparam int CMD_W       = 1;
    localparam int TEX_W       = 3;
    localparam int COLOR_W     = 32;
    localparam int COL_W       = 6;
    localparam int ROW_W       = 12;
    localparam int SPAN_W      = 16;
    localparam int COORD_W     = 16;
    localparam int ANGLE_W     = 16;
    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_SHADE = 1'b1;

    localparam logic [TEX_W-1:0] TEX_NORTH = 3'd0;
    localparam logic [TEX_W-1:0] TEX_SOUTH = 3'd1;
    localparam logic [TEX_W-1:0] TEX_WEST  = 3'd2;
    localparam logic [TEX_W-1:0] TEX_EAST  = 3'd3;
    localparam logic [TEX_W-1:0] TEX_DOOR  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 1'b1;

    localparam logic [ANGLE_W-1:0] ANGLE_ZERO         = 16'h0000;
    localparam logic [ANGLE_W-1:0] QUARTER_TURN       = 16'h4000;
    localparam logic [ANGLE_W-1:0] HALF_TURN          = 16'h8000;
    localparam logic [ANGLE_W-1:0] THREE_QUARTER_TURN = 16'hC000;

endpackage

### design/wcts_ram.sv
// ----------------------------------------------------------------------------
// wcts_ram
// single port RAM with registered read data
// ----------------------------------------------------------------------------
module wcts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/wall_column_texture_sampler_unit.sv
// ----------------------------------------------------------------------------
// wall_column_texture_sampler_unit
// raycaster wall texture lookup: texel writes and per-pixel shade requests
// ----------------------------------------------------------------------------
// A request is taken at a clock edge where start is high and busy is low.
// i_cmd selects a texel write (fills one entry of the five textures) or a
// shade of one wall pixel. A shade picks the texture from door flag, hit side
// and angle quadrant, takes the texture column as hit coordinate mod width and
// the texture row as (y - top) * height / (bottom - top), and returns the texel
// when the row lies in the visible wall span; otherwise nothing comes out.
// Writes never produce a result.
// Results appear on o_pixel_row / o_pixel_color / o_texture_used for one cycle
// with o_result_valid high; the receiver always takes them.
// Throughput: one request per clock once busy has fallen after reset. Depth is
// set by the restoring modulo for the texture column, one quotient bit per
// stage over the 16-bit coordinate; the row division runs in the last
// log2(TEX_DIM) of those stages. Writes and reads hit the texel RAM at the
// same stage, so a shade sees every earlier write. Reset empties the
// pipeline, sets both size registers to 64 and holds busy high; the texel
// RAM is not cleared and must be written first. The user must write the size
// registers on the cfg port only while no request is in flight; the block
// itself does not enforce it.
// ----------------------------------------------------------------------------
module wall_column_texture_sampler_unit
    import wcts_pkg::*;
#(
    parameter int TEX_DIM     = TEX_DIM_DEF,
    parameter int SCREEN_ROWS = SCREEN_ROWS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [CMD_W-1:0]         i_cmd,
    input  logic [TEX_W-1:0]         i_texture_id,
    input  logic [COLOR_W-1:0]       i_texel_value,
    input  logic [COL_W-1:0]         i_column,
    input  logic [ROW_W-1:0]         i_row,
    input  logic signed [SPAN_W-1:0] i_wall_top,
    input  logic signed [SPAN_W-1:0] i_wall_bottom,
    input  logic                     i_hit_vertical,
    input  logic                     i_is_door,
    input  logic [COORD_W-1:0]       i_hit_x,
    input  logic [COORD_W-1:0]       i_hit_y,
    input  logic [ANGLE_W-1:0]       i_view_angle,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    output logic                     o_result_valid,
    output logic [ROW_W-1:0]         o_pixel_row,
    output logic [COLOR_W-1:0]       o_pixel_color,
    output logic [TEX_W-1:0]         o_texture_used
);

    localparam int DIM_W      = $clog2(TEX_DIM + 1);
    localparam int QB         = $clog2(TEX_DIM);
    localparam int TEX_WORDS  = TEX_DIM * TEX_DIM;
    localparam int MEM_DEPTH  = TEX_COUNT * TEX_WORDS;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int DVD_W      = SPAN_W + DIM_W;
    localparam int DIV_STAGES = COORD_W;
    localparam int CREM_X     = COORD_W + DIM_W;
    localparam int RREM_X     = DVD_W + QB;
    localparam int EXT_W      = SPAN_W + 1;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] d;
        if (v == '0) begin
            d = DIM_W'(1);
        end else if (int'(v) > TEX_DIM) begin
            d = DIM_W'(TEX_DIM);
        end else begin
            d = DIM_W'(v);
        end
        return d;
    endfunction

    function automatic logic [TEX_W-1:0] pick_tex(input logic door, input logic vert,
                                                  input logic [ANGLE_W-1:0] ang);
        logic [TEX_W-1:0] t;
        if (door) begin
            t = TEX_DOOR;
        end else if (vert) begin
            t = (ang < QUARTER_TURN || ang > THREE_QUARTER_TURN) ? TEX_EAST : TEX_WEST;
        end else begin
            t = (ang > ANGLE_ZERO && ang < HALF_TURN) ? TEX_SOUTH : TEX_NORTH;
        end
        return t;
    endfunction

    // ---------------- control and size registers ----------------
    logic             r_busy;
    logic [DIM_W-1:0] r_w_eff;
    logic [DIM_W-1:0] r_h_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_w_eff <= eff_dim(CFG_W'(DIM_RESET));
            r_h_eff <= eff_dim(CFG_W'(DIM_RESET));
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TEX_WIDTH:  r_w_eff <= eff_dim(i_cfg_data);
                    CFG_TEX_HEIGHT: r_h_eff <= eff_dim(i_cfg_data);
                    default: ;
                endcase
            end
        end
    end

    assign busy = r_busy;

    // ---------------- stage 1: decode ----------------
    logic                    acc;
    logic signed [EXT_W-1:0] y_s;
    logic signed [EXT_W-1:0] top_s;
    logic signed [EXT_W-1:0] bot_s;
    logic signed [EXT_W-1:0] off_s;
    logic signed [EXT_W-1:0] span_s;
    logic                    in_span;
    logic                    wr_ok;

    assign acc    = start && !r_busy;
    assign y_s    = $signed({{(EXT_W-ROW_W){1'b0}}, i_row});
    assign top_s  = $signed({i_wall_top[SPAN_W-1], i_wall_top});
    assign bot_s  = $signed({i_wall_bottom[SPAN_W-1], i_wall_bottom});
    assign off_s  = y_s - top_s;
    assign span_s = bot_s - top_s;
    // top <= y < bottom also rules out an empty span
    assign in_span = (y_s >= top_s) && (y_s < bot_s) && (int'(i_row) < SCREEN_ROWS);
    assign wr_ok   = (int'(i_texture_id) < TEX_COUNT) && (int'(i_row) < TEX_DIM)
                  && (int'(i_column) < TEX_DIM);

    logic               r_p1_wr;
    logic               r_p1_sh;
    logic [TEX_W-1:0]   r_p1_tex;
    logic [ROW_W-1:0]   r_p1_y;
    logic [QB-1:0]      r_p1_wrow;
    logic [QB-1:0]      r_p1_wcol;
    logic [COLOR_W-1:0] r_p1_wdata;
    logic [COORD_W-1:0] r_p1_coord;
    logic [SPAN_W-1:0]  r_p1_off;
    logic [SPAN_W-1:0]  r_p1_span;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_wr <= 1'b0;
            r_p1_sh <= 1'b0;
        end else begin
            r_p1_wr <= acc && (i_cmd == CMD_WRITE) && wr_ok;
            r_p1_sh <= acc && (i_cmd == CMD_SHADE) && in_span;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_tex   <= (i_cmd == CMD_WRITE) ? i_texture_id
                                           : pick_tex(i_is_door, i_hit_vertical, i_view_angle);
        r_p1_y     <= i_row;
        r_p1_wrow  <= QB'(i_row);
        r_p1_wcol  <= QB'(i_column);
        r_p1_wdata <= i_texel_value;
        r_p1_coord <= i_hit_vertical ? i_hit_y : i_hit_x;
        r_p1_off   <= off_s[SPAN_W-1:0];
        r_p1_span  <= span_s[SPAN_W-1:0];
    end

    // ---------------- stage 2 and divider stages ----------------
    // element 0 holds the product; element s+1 is one restoring step further
    logic               r_wr    [0:DIV_STAGES];
    logic               r_sh    [0:DIV_STAGES];
    logic [TEX_W-1:0]   r_tex   [0:DIV_STAGES];
    logic [ROW_W-1:0]   r_y     [0:DIV_STAGES];
    logic [QB-1:0]      r_wrow  [0:DIV_STAGES];
    logic [QB-1:0]      r_wcol  [0:DIV_STAGES];
    logic [COLOR_W-1:0] r_wdata [0:DIV_STAGES];
    logic [COORD_W-1:0] r_crem  [0:DIV_STAGES];
    logic [DVD_W-1:0]   r_rrem  [0:DIV_STAGES];
    logic [SPAN_W-1:0]  r_span  [0:DIV_STAGES];
    logic [QB-1:0]      r_quo   [0:DIV_STAGES];

    logic [COORD_W-1:0] n_crem [1:DIV_STAGES];
    logic [DVD_W-1:0]   n_rrem [1:DIV_STAGES];
    logic [QB-1:0]      n_quo  [1:DIV_STAGES];

    always_comb begin
        logic [CREM_X-1:0] c_sub;
        logic [RREM_X-1:0] d_sub;
        c_sub = '0;
        d_sub = '0;
        for (int s = 0; s < DIV_STAGES; s++) begin
            // column: hit coordinate mod width, bit DIV_STAGES-1-s
            c_sub = CREM_X'(r_w_eff) << (DIV_STAGES - 1 - s);
            if (CREM_X'(r_crem[s]) >= c_sub) begin
                n_crem[s+1] = r_crem[s] - c_sub[COORD_W-1:0];
            end else begin
                n_crem[s+1] = r_crem[s];
            end
            // row quotient fits in QB bits, so only the last QB stages work on it
            if ((DIV_STAGES - 1 - s) < QB) begin
                d_sub = RREM_X'(r_span[s]) << (DIV_STAGES - 1 - s);
                if (RREM_X'(r_rrem[s]) >= d_sub) begin
                    n_rrem[s+1] = r_rrem[s] - d_sub[DVD_W-1:0];
                    n_quo[s+1]  = {r_quo[s][QB-2:0], 1'b1};
                end else begin
                    n_rrem[s+1] = r_rrem[s];
                    n_quo[s+1]  = {r_quo[s][QB-2:0], 1'b0};
                end
            end else begin
                n_rrem[s+1] = r_rrem[s];
                n_quo[s+1]  = r_quo[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= DIV_STAGES; s++) begin
                r_wr[s] <= 1'b0;
                r_sh[s] <= 1'b0;
            end
        end else begin
            r_wr[0] <= r_p1_wr;
            r_sh[0] <= r_p1_sh;
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_wr[s+1] <= r_wr[s];
                r_sh[s+1] <= r_sh[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tex[0]   <= r_p1_tex;
        r_y[0]     <= r_p1_y;
        r_wrow[0]  <= r_p1_wrow;
        r_wcol[0]  <= r_p1_wcol;
        r_wdata[0] <= r_p1_wdata;
        r_crem[0]  <= r_p1_coord;
        r_rrem[0]  <= {{DIM_W{1'b0}}, r_p1_off} * {{SPAN_W{1'b0}}, r_h_eff};
        r_span[0]  <= r_p1_span;
        r_quo[0]   <= '0;
        for (int s = 0; s < DIV_STAGES; s++) begin
            r_tex[s+1]   <= r_tex[s];
            r_y[s+1]     <= r_y[s];
            r_wrow[s+1]  <= r_wrow[s];
            r_wcol[s+1]  <= r_wcol[s];
            r_wdata[s+1] <= r_wdata[s];
            r_crem[s+1]  <= n_crem[s+1];
            r_rrem[s+1]  <= n_rrem[s+1];
            r_span[s+1]  <= r_span[s];
            r_quo[s+1]   <= n_quo[s+1];
        end
    end

    // ---------------- memory access stage ----------------
    logic [QB-1:0]     sel_row;
    logic [QB-1:0]     sel_col;
    logic [ADDR_W-1:0] n_addr;

    assign sel_row = r_wr[DIV_STAGES] ? r_wrow[DIV_STAGES] : r_quo[DIV_STAGES];
    assign sel_col = r_wr[DIV_STAGES] ? r_wcol[DIV_STAGES] : r_crem[DIV_STAGES][QB-1:0];
    assign n_addr  = ADDR_W'(r_tex[DIV_STAGES]) * ADDR_W'(TEX_WORDS)
                   + ADDR_W'(sel_row) * ADDR_W'(TEX_DIM) + ADDR_W'(sel_col);

    logic               r_ma_we;
    logic               r_ma_re;
    logic [ADDR_W-1:0]  r_ma_addr;
    logic [COLOR_W-1:0] r_ma_wdata;
    logic [ROW_W-1:0]   r_ma_y;
    logic [TEX_W-1:0]   r_ma_tex;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ma_we <= 1'b0;
            r_ma_re <= 1'b0;
        end else begin
            r_ma_we <= r_wr[DIV_STAGES];
            r_ma_re <= r_sh[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ma_addr  <= n_addr;
        r_ma_wdata <= r_wdata[DIV_STAGES];
        r_ma_y     <= r_y[DIV_STAGES];
        r_ma_tex   <= r_tex[DIV_STAGES];
    end

    wcts_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (MEM_DEPTH)
    ) u_texel_ram (
        .i_clk   (i_clk),
        .i_en    (r_ma_we || r_ma_re),
        .i_we    (r_ma_we),
        .i_addr  (r_ma_addr),
        .i_wdata (r_ma_wdata),
        .o_rdata (o_pixel_color)
    );

    // ---------------- output stage ----------------
    logic             r_out_valid;
    logic [ROW_W-1:0] r_out_row;
    logic [TEX_W-1:0] r_out_tex;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_ma_re;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_row <= r_ma_y;
        r_out_tex <= r_ma_tex;
    end

    assign o_result_valid = r_out_valid;
    assign o_pixel_row    = r_out_row;
    assign o_texture_used = r_out_tex;

    // ---------------- assertions ----------------
    a_result_follows_shade: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_p1_sh, DIV_STAGES + 3))
        else $error("result strobe without a shade request in flight");

    a_no_write_and_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_ma_we && r_ma_re))
        else $error("texel ram written and read by one request");

    a_row_below_height: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sh[DIV_STAGES] |-> (DIM_W'(r_quo[DIV_STAGES]) < r_h_eff))
        else $error("texture row not below texture height");

    a_col_below_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sh[DIV_STAGES] |-> (CREM_X'(r_crem[DIV_STAGES]) < CREM_X'(r_w_eff)))
        else $error("texture column not below texture width");

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the wall column texture sampler against its own behavioral
// predictor. A short directed part covers the texture sides, the quadrant
// boundaries, span and screen edges and dropped writes. Random phases follow,
// each after its own texture size register write and, unless the phase turns them off, with random start gaps.
// Every texel a shade reads is written beforehand.
// ----------------------------------------------------------------------------
module testbench;
    import wcts_pkg::*;

    localparam int TEX_DIM         = TEX_DIM_DEF;
    localparam int SCREEN_ROWS     = SCREEN_ROWS_DEF;
    localparam int TEX_WORDS       = TEX_DIM * TEX_DIM;
    localparam int STORE_WORDS     = TEX_COUNT * TEX_WORDS;
    localparam int SETTLE_CYCLES   = COORD_W + 12;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 69;

    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_NONE,
        CHK_PIXEL
    } t_check_mode;

    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic [TEX_W-1:0]         texture_id;
        logic [COLOR_W-1:0]       texel_value;
        logic [COL_W-1:0]         column;
        logic [ROW_W-1:0]         row;
        logic signed [SPAN_W-1:0] wall_top;
        logic signed [SPAN_W-1:0] wall_bottom;
        logic                     hit_vertical;
        logic                     is_door;
        logic [COORD_W-1:0]       hit_x;
        logic [COORD_W-1:0]       hit_y;
        logic [ANGLE_W-1:0]       view_angle;
    } t_sampler_req;

    typedef struct {
        logic [ROW_W-1:0]   row;
        logic [COLOR_W-1:0] color;
        logic [TEX_W-1:0]   tex;
    } t_pixel;

    typedef struct {
        t_sampler_req req;
        t_check_mode  mode;
        t_pixel       pixel;
    } t_directed_row;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [CMD_W-1:0]         i_cmd;
    logic [TEX_W-1:0]         i_texture_id;
    logic [COLOR_W-1:0]       i_texel_value;
    logic [COL_W-1:0]         i_column;
    logic [ROW_W-1:0]         i_row;
    logic signed [SPAN_W-1:0] i_wall_top;
    logic signed [SPAN_W-1:0] i_wall_bottom;
    logic                     i_hit_vertical;
    logic                     i_is_door;
    logic [COORD_W-1:0]       i_hit_x;
    logic [COORD_W-1:0]       i_hit_y;
    logic [ANGLE_W-1:0]       i_view_angle;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CFG_W-1:0]         i_cfg_data;
    logic                     o_result_valid;
    logic [ROW_W-1:0]         o_pixel_row;
    logic [COLOR_W-1:0]       o_pixel_color;
    logic [TEX_W-1:0]         o_texture_used;

    // predictor state
    logic [COLOR_W-1:0] texel_mem [STORE_WORDS];
    bit                 texel_valid [STORE_WORDS];
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;

    t_pixel          pixel_q [$];
    t_directed_row   directed_q [$];
    int unsigned     fail_count = 0;
    int unsigned     cycle_count = 0;
    int unsigned     issued_count = 0;
    bit              gaps_on;

    wall_column_texture_sampler_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_texture_id   (i_texture_id),
        .i_texel_value  (i_texel_value),
        .i_column       (i_column),
        .i_row          (i_row),
        .i_wall_top     (i_wall_top),
        .i_wall_bottom  (i_wall_bottom),
        .i_hit_vertical (i_hit_vertical),
        .i_is_door      (i_is_door),
        .i_hit_x        (i_hit_x),
        .i_hit_y        (i_hit_y),
        .i_view_angle   (i_view_angle),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_pixel_row    (o_pixel_row),
        .o_pixel_color  (o_pixel_color),
        .o_texture_used (o_texture_used)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $time, pixel_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int unsigned clamp_dim(logic [CFG_W-1:0] reg_val);
        if (reg_val == 0)
            return 1;
        if (reg_val > TEX_DIM)
            return TEX_DIM;
        return int'(reg_val);
    endfunction

    function automatic logic [TEX_W-1:0] select_texture(t_sampler_req r);
        if (r.is_door)
            return TEX_DOOR;
        if (r.hit_vertical)
            return (r.view_angle < QUARTER_TURN || r.view_angle > THREE_QUARTER_TURN) ?
                TEX_EAST : TEX_WEST;
        return (r.view_angle != ANGLE_ZERO && r.view_angle < HALF_TURN) ? TEX_SOUTH : TEX_NORTH;
    endfunction

    // returns 1 when the shade draws a pixel, with the texel address it reads
    function automatic bit locate_texel(t_sampler_req r, output int unsigned addr);
        int                 y;
        int                 top;
        int                 bottom;
        int                 first;
        int                 limit;
        int unsigned        w;
        int unsigned        h;
        int unsigned        tcol;
        int unsigned        trow;
        logic [COORD_W-1:0] coord;
        y      = int'(r.row);
        top    = int'(r.wall_top);
        bottom = int'(r.wall_bottom);
        first  = (top < 0) ? 0 : top;
        limit  = (bottom < SCREEN_ROWS) ? bottom : SCREEN_ROWS;
        addr   = 0;
        if (bottom <= top || y < first || y >= limit)
            return 0;
        w     = clamp_dim(width_reg);
        h     = clamp_dim(height_reg);
        coord = r.hit_vertical ? r.hit_y : r.hit_x;
        tcol  = coord % w;
        trow  = ((int'(y - top) * h) / int'(bottom - top)) % h;
        addr  = int'(select_texture(r)) * TEX_WORDS + trow * TEX_DIM + tcol;
        return 1;
    endfunction

    function automatic void predict_request(t_sampler_req r, t_check_mode mode, t_pixel fixed);
        int unsigned addr;
        t_pixel      px;
        if (r.cmd == CMD_WRITE) begin
            if (r.texture_id < TEX_COUNT && r.row < TEX_DIM) begin
                addr = int'(r.texture_id) * TEX_WORDS + int'(r.row) * TEX_DIM + int'(r.column);
                texel_mem[addr]   = r.texel_value;
                texel_valid[addr] = 1'b1;
            end
        end else if (mode == CHK_PIXEL) begin
            pixel_q.push_back(fixed);
        end else if (mode == CHK_PREDICT && locate_texel(r, addr)) begin
            px.row   = r.row;
            px.color = texel_mem[addr];
            px.tex   = select_texture(r);
            pixel_q.push_back(px);
        end
    endfunction

    function automatic t_sampler_req random_request();
        t_sampler_req       r;
        logic [ANGLE_W-1:0] base;
        int                 top;
        int                 bottom;
        int                 first;
        int                 limit;
        r.cmd          = ($urandom_range(0, 3) == 0) ? CMD_WRITE : CMD_SHADE;
        r.texture_id   = ($urandom_range(0, 9) == 0) ? TEX_W'($urandom_range(5, 7))
                                                     : TEX_W'($urandom_range(0, 4));
        r.texel_value  = $urandom;
        r.column       = COL_W'($urandom);
        r.row          = ROW_W'($urandom);
        r.wall_top     = SPAN_W'($urandom);
        r.wall_bottom  = SPAN_W'($urandom);
        r.hit_vertical = 1'($urandom);
        r.is_door      = ($urandom_range(0, 6) == 0);
        r.hit_x        = COORD_W'($urandom);
        r.hit_y        = COORD_W'($urandom);
        r.view_angle   = ANGLE_W'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            // land on or next to a quadrant boundary
            case ($urandom_range(0, 3))
                0: base = ANGLE_ZERO;
                1: base = QUARTER_TURN;
                2: base = HALF_TURN;
                default: base = THREE_QUARTER_TURN;
            endcase
            r.view_angle = base + ANGLE_W'($urandom_range(0, 2)) - ANGLE_W'(1);
        end
        if (r.cmd == CMD_WRITE) begin
            if ($urandom_range(0, 9) != 0)
                r.row = ROW_W'($urandom_range(0, TEX_DIM - 1));
        end else if ($urandom_range(0, 4) != 0) begin
            if ($urandom_range(0, 7) == 0) begin
                top    = -int'($urandom_range(0, 32768));
                bottom = int'($urandom_range(1, 32767));
            end else begin
                top    = int'($urandom_range(0, 1300)) - 200;
                bottom = top + int'($urandom_range(1, 700));
            end
            first         = (top < 0) ? 0 : top;
            limit         = (bottom < SCREEN_ROWS) ? bottom : SCREEN_ROWS;
            r.wall_top    = SPAN_W'(top);
            r.wall_bottom = SPAN_W'(bottom);
            if (first < limit && $urandom_range(0, 7) != 0)
                r.row = ROW_W'($urandom_range(first, limit - 1));
            else
                r.row = ROW_W'($urandom_range(0, SCREEN_ROWS + 100));
        end
        return r;
    endfunction

    function automatic void add_write(logic [TEX_W-1:0] tid, logic [ROW_W-1:0] row,
                                      logic [COL_W-1:0] col, logic [COLOR_W-1:0] value);
        t_directed_row d;
        d.req             = random_request();
        d.req.cmd         = CMD_WRITE;
        d.req.texture_id  = tid;
        d.req.row         = row;
        d.req.column      = col;
        d.req.texel_value = value;
        d.mode            = CHK_PREDICT;
        d.pixel           = '{default: '0};
        directed_q.push_back(d);
    endfunction

    function automatic void add_shade(logic [ROW_W-1:0] y, int top, int bottom, bit vertical,
                                      bit door, logic [COORD_W-1:0] hx, logic [COORD_W-1:0] hy,
                                      logic [ANGLE_W-1:0] angle, t_check_mode mode,
                                      logic [COLOR_W-1:0] color, logic [TEX_W-1:0] tex);
        t_directed_row d;
        d.req              = random_request();
        d.req.cmd          = CMD_SHADE;
        d.req.row          = y;
        d.req.wall_top     = SPAN_W'(top);
        d.req.wall_bottom  = SPAN_W'(bottom);
        d.req.hit_vertical = vertical;
        d.req.is_door      = door;
        d.req.hit_x        = hx;
        d.req.hit_y        = hy;
        d.req.view_angle   = angle;
        d.mode             = mode;
        d.pixel.row        = y;
        d.pixel.color      = color;
        d.pixel.tex        = tex;
        directed_q.push_back(d);
    endfunction

    function automatic void build_directed();
        // corner texels of each side, read back at default 64x64 sizes
        add_write(TEX_NORTH, 0, 0, 32'hDEADBEEF);
        add_write(TEX_SOUTH, 63, 63, 32'hFFFFFFFF);
        add_write(TEX_WEST, 0, 63, 32'h00000000);
        add_write(TEX_EAST, 63, 0, 32'h12345678);
        add_write(TEX_DOOR, 0, 0, 32'hA5A5A5A5);
        add_shade(0, 0, 64, 0, 0, 0, 0, ANGLE_ZERO, CHK_PIXEL, 32'hDEADBEEF, TEX_NORTH);
        add_shade(63, 0, 64, 0, 0, 63, 0, 16'h7FFF, CHK_PIXEL, 32'hFFFFFFFF, TEX_SOUTH);
        add_shade(0, 0, 64, 1, 0, 0, 63, QUARTER_TURN, CHK_PIXEL, 32'h00000000, TEX_WEST);
        add_shade(63, 0, 64, 1, 0, 0, 64, 16'hC001, CHK_PIXEL, 32'h12345678, TEX_EAST);
        add_shade(0, 0, 64, 0, 1, 0, 0, 16'hFFFF, CHK_PIXEL, 32'hA5A5A5A5, TEX_DOOR);
        // no pixel: past the span, above the span, empty, inverted, below the screen
        add_shade(64, 0, 64, 0, 0, 0, 0, ANGLE_ZERO, CHK_NONE, 0, TEX_NORTH);
        add_shade(499, 500, 600, 0, 0, 0, 0, ANGLE_ZERO, CHK_NONE, 0, TEX_NORTH);
        add_shade(10, 10, 10, 0, 0, 0, 0, ANGLE_ZERO, CHK_NONE, 0, TEX_NORTH);
        add_shade(50, 100, -5, 0, 0, 0, 0, ANGLE_ZERO, CHK_NONE, 0, TEX_NORTH);
        add_shade(1024, 0, 2000, 0, 0, 0, 0, ANGLE_ZERO, CHK_NONE, 0, TEX_NORTH);
        // out of range writes must be dropped, not alias onto north
        add_write(5, 0, 0, 32'h0BADF00D);
        add_write(7, 4095, 63, 32'h0BADF00D);
        add_write(TEX_NORTH, 64, 0, 32'h0BADF00D);
        add_shade(0, 0, 64, 0, 0, 0, 0, ANGLE_ZERO, CHK_PIXEL, 32'hDEADBEEF, TEX_NORTH);
        // widest span, boundaries of the angle quadrants
        add_shade(0, -32768, 32767, 0, 0, 16'hFFFF, 0, HALF_TURN, CHK_PREDICT, 0, TEX_NORTH);
        add_shade(1023, 1000, 32767, 1, 0, 0, 16'hFFFF, THREE_QUARTER_TURN,
                  CHK_PREDICT, 0, TEX_NORTH);
        add_shade(5, 5, 6, 1, 0, 0, 16'h1234, 16'h3FFF, CHK_PREDICT, 0, TEX_NORTH);
        add_shade(17, 0, 40, 0, 0, 16'h8001, 0, 16'h0001, CHK_PREDICT, 0, TEX_NORTH);
        add_shade(300, 0, 1023, 0, 0, 16'h7FFE, 0, 16'hFFFF, CHK_PREDICT, 0, TEX_NORTH);
        add_shade(0, -10, 20, 1, 0, 0, 16'hAAAA, 16'hC000, CHK_PREDICT, 0, TEX_NORTH);
    endfunction

    function automatic int unsigned draw_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (!gaps_on || pick < 60)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic issue(t_sampler_req r, t_check_mode mode, t_pixel fixed);
        @(negedge i_clk);
        start          <= 1'b1;
        i_cmd          <= r.cmd;
        i_texture_id   <= r.texture_id;
        i_texel_value  <= r.texel_value;
        i_column       <= r.column;
        i_row          <= r.row;
        i_wall_top     <= r.wall_top;
        i_wall_bottom  <= r.wall_bottom;
        i_hit_vertical <= r.hit_vertical;
        i_is_door      <= r.is_door;
        i_hit_x        <= r.hit_x;
        i_hit_y        <= r.hit_y;
        i_view_angle   <= r.view_angle;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        predict_request(r, mode, fixed);
        issued_count++;
    endtask

    // a shade that would read a never written texel gets that texel written first
    task automatic send_request(t_sampler_req r, t_check_mode mode, t_pixel fixed);
        int unsigned  addr;
        t_sampler_req fill;
        if (r.cmd == CMD_SHADE && locate_texel(r, addr) && !texel_valid[addr]) begin
            fill            = random_request();
            fill.cmd        = CMD_WRITE;
            fill.texture_id = TEX_W'(addr / TEX_WORDS);
            fill.row        = ROW_W'((addr % TEX_WORDS) / TEX_DIM);
            fill.column     = COL_W'(addr % TEX_DIM);
            issue(fill, CHK_PREDICT, fixed);
        end
        issue(r, mode, fixed);
    endtask

    task automatic idle_sender(int unsigned cycles);
        if (cycles != 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (cycles - 1)
                @(negedge i_clk);
        end
    endtask

    // hold off until every pixel is back and the pipeline has flushed writes too
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (pixel_q.size() != 0 || busy)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES)
            @(posedge i_clk);
    endtask

    task automatic write_sizes(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TEX_WIDTH;
        i_cfg_data  <= w;
        @(negedge i_clk);
        i_cfg_index <= CFG_TEX_HEIGHT;
        i_cfg_data  <= h;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        width_reg  = w;
        height_reg = h;
    endtask

    function automatic void check_field(string name, logic [31:0] expected, logic [31:0] actual);
        if (actual !== expected) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expected, actual);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_pixel want;
        if (i_rst_n && o_result_valid) begin
            if (pixel_q.size() == 0) begin
                $display("%0t: unexpected result row %0d color %h texture %0d",
                         $time, o_pixel_row, o_pixel_color, o_texture_used);
                fail_count++;
            end else begin
                want = pixel_q.pop_front();
                check_field("pixel_row", 32'(want.row), 32'(o_pixel_row));
                check_field("pixel_color", want.color, o_pixel_color);
                check_field("texture_used", 32'(want.tex), 32'(o_texture_used));
            end
        end
    end

    initial begin
        int unsigned      sent;
        logic [CFG_W-1:0] w_size;
        logic [CFG_W-1:0] h_size;
        t_pixel           no_pixel;
        t_sampler_req     next_req;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_cmd          = CMD_WRITE;
        i_texture_id   = TEX_NORTH;
        i_texel_value  = '0;
        i_column       = '0;
        i_row          = '0;
        i_wall_top     = '0;
        i_wall_bottom  = '0;
        i_hit_vertical = 1'b0;
        i_is_door      = 1'b0;
        i_hit_x        = '0;
        i_hit_y        = '0;
        i_view_angle   = ANGLE_ZERO;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_TEX_WIDTH;
        i_cfg_data     = '0;
        width_reg      = CFG_W'(DIM_RESET);
        height_reg     = CFG_W'(DIM_RESET);
        no_pixel       = '{default: '0};
        gaps_on        = 1'b1;
        repeat (6)
            @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        build_directed();
        foreach (directed_q[i]) begin
            send_request(directed_q[i].req, directed_q[i].mode, directed_q[i].pixel);
            idle_sender(draw_gap());
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin w_size = 1;   h_size = 1;   end
                1: begin w_size = 0;   h_size = 0;   end
                2: begin w_size = 127; h_size = 127; end
                3: begin w_size = 64;  h_size = 1;   end
                4: begin w_size = 1;   h_size = 64;  end
                5: begin w_size = 65;  h_size = 3;   end
                8: begin w_size = 64;  h_size = 64;  end
                default: begin
                    w_size = CFG_W'($urandom_range(0, 127));
                    h_size = CFG_W'($urandom_range(0, 127));
                end
            endcase
            drain();
            write_sizes(w_size, h_size);
            gaps_on = ($urandom_range(0, 3) != 0);
            // every accepted request counts, texel fills and dropped writes too
            sent = issued_count;
            while (issued_count - sent < ITEMS_PER_PHASE) begin
                next_req = random_request();
                send_request(next_req, CHK_PREDICT, no_pixel);
                idle_sender(draw_gap());
            end
        end

        drain();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
